@@ hw/rtl/clamped_bilinear_table_interpolator_assert.svh @@
// assertion macros shared by the interpolator rtl
`ifndef CLAMPED_BILINEAR_TABLE_INTERPOLATOR_ASSERT_SVH
`define CLAMPED_BILINEAR_TABLE_INTERPOLATOR_ASSERT_SVH
`ifndef ASSERT_OFF
`define CBTI_ASSERT(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);
`define CBTI_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`else
`define CBTI_ASSERT(label, expr, msg)
`define CBTI_ASSERT_IMP(label, ante, cons, msg)
`endif
`endif

@@ hw/rtl/cbti_pkg.sv @@
// shared types and constants of the clamped bilinear table interpolator
`default_nettype none

package cbti_pkg;

	localparam int X_POINTS_MAX_DEF = 64;
	localparam int Y_POINTS_MAX_DEF = 64;

	localparam int DATA_W    = 32;
	localparam int COORD_W   = 32;
	localparam int SCALE_W   = 32;
	localparam int PTS_CFG_W = 7;
	localparam int IDX_W     = 6;
	localparam int CFG_IDX_W = 3;
	localparam int FRAC_W    = 16;
	localparam int WGT_W     = FRAC_W + 1;
	localparam int CELL_W    = 10;
	localparam int PTS_W     = CELL_W + 1;
	localparam int ADDR_W    = 2 * CELL_W;
	localparam int NUM_BANKS = 4;

	localparam int QUEUE_DEPTH = 8;
	localparam int OUT_DEPTH   = 8;

	localparam logic [WGT_W-1:0] ONE_Q16 = {1'b1, {FRAC_W{1'b0}}};

	localparam logic [COORD_W-1:0]   X_LOWER_RST  = 32'h0000_0000;
	localparam logic [COORD_W-1:0]   X_UPPER_RST  = 32'h0001_0000;
	localparam logic [SCALE_W-1:0]   X_SCALE_RST  = 32'h0001_0000;
	localparam logic [COORD_W-1:0]   Y_LOWER_RST  = 32'h0000_0000;
	localparam logic [COORD_W-1:0]   Y_UPPER_RST  = 32'h0001_0000;
	localparam logic [SCALE_W-1:0]   Y_SCALE_RST  = 32'h0001_0000;
	localparam logic [PTS_CFG_W-1:0] X_POINTS_RST = 7'd64;
	localparam logic [PTS_CFG_W-1:0] Y_POINTS_RST = 7'd64;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_X_LOWER  = 3'd0,
		REG_X_UPPER  = 3'd1,
		REG_X_SCALE  = 3'd2,
		REG_Y_LOWER  = 3'd3,
		REG_Y_UPPER  = 3'd4,
		REG_Y_SCALE  = 3'd5,
		REG_X_POINTS = 3'd6,
		REG_Y_POINTS = 3'd7
	} cfg_reg_t;

	typedef enum logic {
		OP_WRITE = 1'b0,
		OP_QUERY = 1'b1
	} opcode_t;

	// one classified item between front and back, bank b = {row parity, column parity}
	typedef struct packed {
		logic                                is_query;
		logic                                wr_en;
		logic                                par_x;
		logic                                par_y;
		logic [NUM_BANKS-1:0][ADDR_W-1:0]    addr;
		logic [DATA_W-1:0]                   data;
		logic [WGT_W-1:0]                    fx;
		logic [WGT_W-1:0]                    fy;
	} entry_t;

endpackage

`default_nettype wire

@@ hw/rtl/cbti_fifo.sv @@
// small register queue with occupancy flags
`default_nettype none

module cbti_fifo #(
	parameter int WIDTH = cbti_pkg::DATA_W,
	parameter int DEPTH = cbti_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             pop,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty,
	output logic             full
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign rd_data = mem_q[rd_ptr_q];
	assign empty   = (count_q == '0);
	assign full    = (count_q == CNT_W'(DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/cbti_front.sv @@
// front end: config registers, axis clamping, cell and fraction location, bank addressing
`default_nettype none

`include "clamped_bilinear_table_interpolator_assert.svh"

module cbti_front #(
	parameter int X_POINTS_MAX = cbti_pkg::X_POINTS_MAX_DEF,
	parameter int Y_POINTS_MAX = cbti_pkg::Y_POINTS_MAX_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic                                  opcode,
	input  logic [cbti_pkg::IDX_W-1:0]            entry_column,
	input  logic [cbti_pkg::IDX_W-1:0]            entry_row,
	input  logic signed [cbti_pkg::DATA_W-1:0]    entry_value,
	input  logic signed [cbti_pkg::COORD_W-1:0]   query_x,
	input  logic signed [cbti_pkg::COORD_W-1:0]   query_y,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [cbti_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [cbti_pkg::DATA_W-1:0]           cfg_data,
	output logic                                  q_push,
	output cbti_pkg::entry_t                      q_entry,
	input  logic                                  q_pop
);

	import cbti_pkg::*;

	localparam int RESV_W = $clog2(QUEUE_DEPTH + 1);
	localparam int X_HALF = (X_POINTS_MAX + 1) / 2;

	typedef struct packed {
		logic [CELL_W-1:0] seg;
		logic [WGT_W-1:0]  frac;
	} axis_t;

	function automatic axis_t pick(input logic below, input logic above,
			input logic [2*SCALE_W-1:0] t, input logic [CELL_W-1:0] last);
		axis_t r;
		if (below) begin
			r.seg  = '0;
			r.frac = '0;
		end else if (above || (t[2*SCALE_W-1:SCALE_W] > 32'(last))) begin
			r.seg  = last;
			r.frac = ONE_Q16;
		end else begin
			r.seg  = t[SCALE_W+CELL_W-1:SCALE_W];
			r.frac = {1'b0, t[SCALE_W-1:FRAC_W]};
		end
		return r;
	endfunction

	logic signed [COORD_W-1:0] x_lower_q, x_upper_q, y_lower_q, y_upper_q;
	logic [SCALE_W-1:0]        x_scale_q, y_scale_q;
	logic [PTS_CFG_W-1:0]      x_points_q, y_points_q;

	logic              accept;
	logic [RESV_W-1:0] resv_q;

	logic [COORD_W:0]  diff_x, diff_y;

	logic              v_s1, v_s2, v_s3, v_s4;
	logic              q_s1, q_s2, q_s3;
	logic              we_s1, we_s2, we_s3;
	logic [IDX_W-1:0]  col_s1, col_s2, row_s1, row_s2;
	logic [DATA_W-1:0] data_s1, data_s2, data_s3;
	logic              bx_s1, ax_s1, by_s1, ay_s1;
	logic              bx_s2, ax_s2, by_s2, ay_s2;
	logic [SCALE_W-1:0]   diff_x_s1, diff_y_s1;
	logic [2*SCALE_W-1:0] tx_s2, ty_s2;
	logic [CELL_W-1:0] cx_s3, cy_s3;
	logic [WGT_W-1:0]  fx_s3, fy_s3;
	entry_t            entry_s4;

	logic [PTS_W-1:0]  nx, ny;
	logic [CELL_W-1:0] last_x, last_y;
	axis_t             loc_x, loc_y;

	logic [CELL_W-1:0] col_b [NUM_BANKS];
	logic [CELL_W-1:0] row_b [NUM_BANKS];
	logic [ADDR_W-1:0] addr_b [NUM_BANKS];

	assign cfg_ready = 1'b1;
	assign in_ready  = (resv_q < RESV_W'(QUEUE_DEPTH));
	assign accept    = in_valid && in_ready;
	assign q_push    = v_s4;
	assign q_entry   = entry_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_lower_q  <= X_LOWER_RST;
			x_upper_q  <= X_UPPER_RST;
			x_scale_q  <= X_SCALE_RST;
			y_lower_q  <= Y_LOWER_RST;
			y_upper_q  <= Y_UPPER_RST;
			y_scale_q  <= Y_SCALE_RST;
			x_points_q <= X_POINTS_RST;
			y_points_q <= Y_POINTS_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_X_LOWER:  x_lower_q  <= cfg_data;
				REG_X_UPPER:  x_upper_q  <= cfg_data;
				REG_X_SCALE:  x_scale_q  <= cfg_data;
				REG_Y_LOWER:  y_lower_q  <= cfg_data;
				REG_Y_UPPER:  y_upper_q  <= cfg_data;
				REG_Y_SCALE:  y_scale_q  <= cfg_data;
				REG_X_POINTS: x_points_q <= cfg_data[PTS_CFG_W-1:0];
				REG_Y_POINTS: y_points_q <= cfg_data[PTS_CFG_W-1:0];
			endcase
		end
	end

	// items reserved in the front pipeline and the work queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			resv_q <= '0;
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
		end else begin
			resv_q <= resv_q + RESV_W'(accept) - RESV_W'(q_pop);
			v_s1   <= accept;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			v_s4   <= v_s3;
		end
	end

	assign diff_x = {query_x[COORD_W-1], query_x} - {x_lower_q[COORD_W-1], x_lower_q};
	assign diff_y = {query_y[COORD_W-1], query_y} - {y_lower_q[COORD_W-1], y_lower_q};

	always_ff @(posedge clk) begin
		q_s1      <= (opcode_t'(opcode) == OP_QUERY);
		we_s1     <= (opcode_t'(opcode) == OP_WRITE) && (32'(entry_column) < X_POINTS_MAX)
			&& (32'(entry_row) < Y_POINTS_MAX);
		col_s1    <= entry_column;
		row_s1    <= entry_row;
		data_s1   <= entry_value;
		bx_s1     <= (query_x < x_lower_q);
		ax_s1     <= (query_x > x_upper_q);
		by_s1     <= (query_y < y_lower_q);
		ay_s1     <= (query_y > y_upper_q);
		diff_x_s1 <= diff_x[COORD_W-1:0];
		diff_y_s1 <= diff_y[COORD_W-1:0];
	end

	always_ff @(posedge clk) begin
		q_s2    <= q_s1;
		we_s2   <= we_s1;
		col_s2  <= col_s1;
		row_s2  <= row_s1;
		data_s2 <= data_s1;
		bx_s2   <= bx_s1;
		ax_s2   <= ax_s1;
		by_s2   <= by_s1;
		ay_s2   <= ay_s1;
		tx_s2   <= diff_x_s1 * x_scale_q;
		ty_s2   <= diff_y_s1 * y_scale_q;
	end

	always_comb begin
		if (PTS_W'(x_points_q) < PTS_W'(2)) begin
			nx = PTS_W'(2);
		end else if (PTS_W'(x_points_q) > PTS_W'(X_POINTS_MAX)) begin
			nx = PTS_W'(X_POINTS_MAX);
		end else begin
			nx = PTS_W'(x_points_q);
		end
		if (PTS_W'(y_points_q) < PTS_W'(2)) begin
			ny = PTS_W'(2);
		end else if (PTS_W'(y_points_q) > PTS_W'(Y_POINTS_MAX)) begin
			ny = PTS_W'(Y_POINTS_MAX);
		end else begin
			ny = PTS_W'(y_points_q);
		end
		last_x = CELL_W'(nx - PTS_W'(2));
		last_y = CELL_W'(ny - PTS_W'(2));
		loc_x  = pick(bx_s2, ax_s2, tx_s2, last_x);
		loc_y  = pick(by_s2, ay_s2, ty_s2, last_y);
	end

	// a write rides the same path with its column and row in place of the cell
	always_ff @(posedge clk) begin
		q_s3    <= q_s2;
		we_s3   <= we_s2;
		data_s3 <= data_s2;
		cx_s3   <= q_s2 ? loc_x.seg : CELL_W'(col_s2);
		cy_s3   <= q_s2 ? loc_y.seg : CELL_W'(row_s2);
		fx_s3   <= loc_x.frac;
		fy_s3   <= loc_y.frac;
	end

	always_comb begin
		for (int b = 0; b < NUM_BANKS; b++) begin
			col_b[b]  = cx_s3 + CELL_W'(cx_s3[0] != 1'(b));
			row_b[b]  = cy_s3 + CELL_W'(cy_s3[0] != 1'(b >> 1));
			addr_b[b] = ADDR_W'(row_b[b][CELL_W-1:1]) * ADDR_W'(X_HALF)
				+ ADDR_W'(col_b[b][CELL_W-1:1]);
		end
	end

	always_ff @(posedge clk) begin
		entry_s4.is_query <= q_s3;
		entry_s4.wr_en    <= we_s3;
		entry_s4.par_x    <= cx_s3[0];
		entry_s4.par_y    <= cy_s3[0];
		entry_s4.data     <= data_s3;
		entry_s4.fx       <= fx_s3;
		entry_s4.fy       <= fy_s3;
		for (int b = 0; b < NUM_BANKS; b++) begin
			entry_s4.addr[b] <= addr_b[b];
		end
	end

	`CBTI_ASSERT(a_resv_bound, resv_q <= RESV_W'(QUEUE_DEPTH), "front reservation overrun")
	`CBTI_ASSERT(a_resv_pipe, $countones({v_s1, v_s2, v_s3, v_s4}) <= int'(resv_q), "pipe unreserved")
	`CBTI_ASSERT_IMP(a_pop_reserved, q_pop, resv_q != '0, "work queue pop without reservation")

endmodule

`default_nettype wire

@@ hw/rtl/cbti_back.sv @@
// back end: banked grid store, corner weights, products, sum and saturation
`default_nettype none

`include "clamped_bilinear_table_interpolator_assert.svh"

module cbti_back #(
	parameter int X_POINTS_MAX = cbti_pkg::X_POINTS_MAX_DEF,
	parameter int Y_POINTS_MAX = cbti_pkg::Y_POINTS_MAX_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  cbti_pkg::entry_t                     q_entry,
	input  logic                                 q_empty,
	output logic                                 q_pop,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [cbti_pkg::DATA_W-1:0]   interpolated
);

	import cbti_pkg::*;

	localparam int BANK_DEPTH = ((X_POINTS_MAX + 1) / 2) * ((Y_POINTS_MAX + 1) / 2);
	localparam int AW         = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
	localparam int CRED_W     = $clog2(OUT_DEPTH + 1);
	localparam int PROD_W     = DATA_W + WGT_W + 1;
	localparam int SUM_W      = PROD_W + 2;

	logic [CRED_W-1:0] credit_q;
	logic              pop_query;
	logic              out_accept;
	logic              out_push;
	logic              out_empty;
	logic              out_full;
	logic [DATA_W-1:0] result;

	logic [WGT_W-1:0]   wx [2];
	logic [WGT_W-1:0]   wy [2];
	logic [2*WGT_W-1:0] wprod [NUM_BANKS];

	logic                     vq_s1, vq_s2, vq_s3;
	logic                     px_s1, py_s1;
	logic [WGT_W-1:0]         w_s1 [NUM_BANKS];
	logic signed [DATA_W-1:0] rd_s1 [NUM_BANKS];
	logic signed [PROD_W-1:0] p_s2 [NUM_BANKS];
	logic [PROD_W:0]          sum_s3 [2];

	logic [SUM_W-1:0]           acc;
	logic [SUM_W-FRAC_W-1:0]    shifted;

	// a query pops only with room for its result guaranteed downstream
	assign q_pop      = !q_empty && (!q_entry.is_query || (credit_q < CRED_W'(OUT_DEPTH)));
	assign pop_query  = q_pop && q_entry.is_query;
	assign out_valid  = !out_empty;
	assign out_accept = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= '0;
			vq_s1    <= 1'b0;
			vq_s2    <= 1'b0;
			vq_s3    <= 1'b0;
		end else begin
			credit_q <= credit_q + CRED_W'(pop_query) - CRED_W'(out_accept);
			vq_s1    <= pop_query;
			vq_s2    <= vq_s1;
			vq_s3    <= vq_s2;
		end
	end

	genvar gb;
	generate
		for (gb = 0; gb < NUM_BANKS; gb++) begin : g_bank
			logic [DATA_W-1:0] mem [BANK_DEPTH];
			logic              we;

			assign we = q_pop && q_entry.wr_en && ({q_entry.par_y, q_entry.par_x} == 2'(gb));

			always_ff @(posedge clk) begin
				if (we) begin
					mem[q_entry.addr[gb][AW-1:0]] <= q_entry.data;
				end
				rd_s1[gb] <= mem[q_entry.addr[gb][AW-1:0]];
			end
		end
	endgenerate

	always_comb begin
		wx[0] = ONE_Q16 - q_entry.fx;
		wx[1] = q_entry.fx;
		wy[0] = ONE_Q16 - q_entry.fy;
		wy[1] = q_entry.fy;
		for (int k = 0; k < NUM_BANKS; k++) begin
			wprod[k] = wx[k % 2] * wy[k / 2];
		end
	end

	always_ff @(posedge clk) begin
		px_s1 <= q_entry.par_x;
		py_s1 <= q_entry.par_y;
		for (int k = 0; k < NUM_BANKS; k++) begin
			w_s1[k] <= wprod[k][FRAC_W+WGT_W-1:FRAC_W];
		end
	end

	// corner k = {dy, dx} sits in bank {row parity, column parity}
	always_ff @(posedge clk) begin
		for (int k = 0; k < NUM_BANKS; k++) begin
			p_s2[k] <= $signed({1'b0, w_s1[k]}) * rd_s1[{py_s1 ^ 1'(k >> 1), px_s1 ^ 1'(k)}];
		end
	end

	always_ff @(posedge clk) begin
		sum_s3[0] <= {p_s2[0][PROD_W-1], p_s2[0]} + {p_s2[1][PROD_W-1], p_s2[1]};
		sum_s3[1] <= {p_s2[2][PROD_W-1], p_s2[2]} + {p_s2[3][PROD_W-1], p_s2[3]};
	end

	always_comb begin
		acc     = {sum_s3[0][PROD_W], sum_s3[0]} + {sum_s3[1][PROD_W], sum_s3[1]};
		shifted = acc[SUM_W-1:FRAC_W];
		if (shifted[SUM_W-FRAC_W-1:DATA_W-1] == '0
				|| shifted[SUM_W-FRAC_W-1:DATA_W-1] == '1) begin
			result = shifted[DATA_W-1:0];
		end else if (shifted[SUM_W-FRAC_W-1]) begin
			result = {1'b1, {(DATA_W-1){1'b0}}};
		end else begin
			result = {1'b0, {(DATA_W-1){1'b1}}};
		end
	end

	assign out_push = vq_s3;

	cbti_fifo #(
		.WIDTH (DATA_W),
		.DEPTH (OUT_DEPTH)
	) u_result (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (out_push),
		.wr_data (result),
		.pop     (out_accept),
		.rd_data (interpolated),
		.empty   (out_empty),
		.full    (out_full)
	);

	`CBTI_ASSERT(a_credit_bound, credit_q <= CRED_W'(OUT_DEPTH), "result credits overrun")
	`CBTI_ASSERT_IMP(a_no_result_overflow, out_push, !out_full, "result pushed into full queue")
	`CBTI_ASSERT_IMP(a_push_latency, out_push, $past(pop_query, 3), "result without matching query")
	`CBTI_ASSERT_IMP(a_pop_nonempty, q_pop, !q_empty, "work queue popped while empty")

endmodule

`default_nettype wire

@@ hw/rtl/clamped_bilinear_table_interpolator.sv @@
// top level of the clamped bilinear table interpolator
//
//   channel | handshake            | payload
//   --------+----------------------+----------------------------------------------
//   in      | in_valid / in_ready  | opcode, entry_column, entry_row, entry_value,
//           |                      | query_x, query_y
//   out     | out_valid/ out_ready | interpolated
//   cfg     | cfg_valid/ cfg_ready | cfg_index, cfg_data
//
// one write or query transaction per cycle while in_ready is high; each query result is
// offered in order, with the four cell corners read together from four parity banks
// reset clears pipeline valids, queues, credits and config registers; grid contents
// are undefined until written, with no clearing pass
// with out_ready low the 8-entry result queue fills, then the 8-entry work queue,
// and in_ready drops; a write needs no result room but waits behind a stalled query
`default_nettype none

module clamped_bilinear_table_interpolator #(
	parameter int X_POINTS_MAX = cbti_pkg::X_POINTS_MAX_DEF,
	parameter int Y_POINTS_MAX = cbti_pkg::Y_POINTS_MAX_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic                                  opcode,
	input  logic [cbti_pkg::IDX_W-1:0]            entry_column,
	input  logic [cbti_pkg::IDX_W-1:0]            entry_row,
	input  logic signed [cbti_pkg::DATA_W-1:0]    entry_value,
	input  logic signed [cbti_pkg::COORD_W-1:0]   query_x,
	input  logic signed [cbti_pkg::COORD_W-1:0]   query_y,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [cbti_pkg::DATA_W-1:0]    interpolated,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [cbti_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [cbti_pkg::DATA_W-1:0]           cfg_data
);

	import cbti_pkg::*;

	logic   q_push;
	logic   q_pop;
	logic   q_empty;
	entry_t q_tail;
	entry_t q_head;

	cbti_front #(
		.X_POINTS_MAX (X_POINTS_MAX),
		.Y_POINTS_MAX (Y_POINTS_MAX)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.opcode       (opcode),
		.entry_column (entry_column),
		.entry_row    (entry_row),
		.entry_value  (entry_value),
		.query_x      (query_x),
		.query_y      (query_y),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.q_push       (q_push),
		.q_entry      (q_tail),
		.q_pop        (q_pop)
	);

	cbti_fifo #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.wr_data (q_tail),
		.pop     (q_pop),
		.rd_data (q_head),
		.empty   (q_empty),
		.full    ()
	);

	cbti_back #(
		.X_POINTS_MAX (X_POINTS_MAX),
		.Y_POINTS_MAX (Y_POINTS_MAX)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_entry      (q_head),
		.q_empty      (q_empty),
		.q_pop        (q_pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.interpolated (interpolated)
	);

endmodule

`default_nettype wire
